[hw/rtl/wd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wd_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_WR_THREADING = 2'd0,
        OP_WR_TIEUP     = 2'd1,
        OP_WR_TREADLING = 2'd2,
        OP_RD_CLOTH     = 2'd3
    } t_op;

    // Configuration register indexes and port widths
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_LIFTPLAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARPS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TREADLES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PICKS    = 2'd3;

    localparam logic [8:0] RST_WARPS    = 9'd256;
    localparam logic [5:0] RST_TREADLES = 6'd32;
    localparam logic [8:0] RST_PICKS    = 9'd256;

    typedef struct packed {
        t_op        op;
        logic [7:0] warp_index;
        logic [7:0] pick_index;
        logic [4:0] treadle_index;
        logic [4:0] shaft_index;
        logic [5:0] shaft_number;
        logic [3:0] cell_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] cloth_value;
        logic [7:0] warp_out;
        logic [7:0] pick_out;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted item
        logic wr;        // perform the latched store write
        logic clr;       // clear one entry of every store deep enough to hold it
        logic thr_rd;    // read threading for the latched warp
        logic res_clr;   // clear result and treadle counter
        logic lp_rd;     // read lift plan entry
        logic lp_take;   // take lift plan entry as result
        logic scan_rd;   // read tie-up and treadling for one treadle
        logic out_load;  // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_write;   // incoming item is a store write
        logic clr_last;   // clearing pass at its last entry
        logic early_zero; // cell reads 0 without a scan
        logic liftplan;   // lift plan mode
        logic k_last;     // scan at its last treadle
    } t_stat;

endpackage

`default_nettype wire

[hw/rtl/weave_drawdown.sv]
`timescale 1ns / 1ps
`default_nettype none
// A store write is latched on acceptance, then written. A cloth read reads the threading, then
// scans lim treadles in normal mode (lim = treadles scanned, one per cycle through the tie-up
// and treadling read ports) and drains, or reads the lift plan in lift plan mode, or skips both
// for a cell that reads 0. No item is taken until the last read's result is in the output
// register. Reset: synchronous, active low; afterwards a clearing pass zeroes every store, one
// entry per cycle over the largest store (8192 at default sizes) while no item is accepted.
module weave_drawdown #(
    parameter int unsigned MAX_WARPS    = 256,
    parameter int unsigned MAX_TREADLES = 32,
    parameter int unsigned MAX_PICKS    = 256,
    parameter int unsigned MAX_SHAFTS   = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wd_pkg::t_in_item                   i_in_data,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output wd_pkg::t_out_item                  o_out_data,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [wd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import wd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: clearing pass, item acceptance, read steps and the output handoff.
    // The output register frees the item side: a new transaction is taken while a
    // finished result still waits for the consumer.
    wd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: configuration registers, the three stores with registered reads,
    // the treadle counter and the result register. A normal-mode read walks the
    // treadles in index order and keeps the tie-up value of the last one that is
    // both tied to the warp's shaft and pressed on the pick.
    wd_dp #(
        .MAX_WARPS    (MAX_WARPS),
        .MAX_TREADLES (MAX_TREADLES),
        .MAX_PICKS    (MAX_PICKS),
        .MAX_SHAFTS   (MAX_SHAFTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // No transaction is taken while the stores are being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> !o_in_ready)
        else $error("item accepted during clearing pass");

    // A result never overwrites one the consumer has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    // No result comes in the cycle right after acceptance.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !cmd.out_load)
        else $error("result loaded directly after acceptance");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

[hw/rtl/wd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module wd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wd_pkg::t_stat      i_stat,
    output wd_pkg::t_cmd       o_cmd
);
    import wd_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_WRITE  = 9'b000000100,
        S_THR    = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_LIFT   = 9'b000100000,
        S_SCAN   = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.is_write ? S_WRITE : S_THR;
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_IDLE;
            end
            S_THR: begin
                o_cmd.thr_rd = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.res_clr = 1'b1;
                if (i_stat.early_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.liftplan) begin
                    o_cmd.lp_rd = 1'b1;
                    n_state     = S_LIFT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_LIFT: begin
                o_cmd.lp_take = 1'b1;
                n_state       = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/wd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module wd_dp #(
    parameter int unsigned MAX_WARPS    = 256,
    parameter int unsigned MAX_TREADLES = 32,
    parameter int unsigned MAX_PICKS    = 256,
    parameter int unsigned MAX_SHAFTS   = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wd_pkg::t_in_item                   i_in_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [wd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wd_pkg::t_cmd                       i_cmd,
    output wd_pkg::t_stat                      o_stat,
    output wd_pkg::t_out_item                  o_out_data
);
    import wd_pkg::*;

    localparam int unsigned TR_ROWS   = (MAX_TREADLES > MAX_SHAFTS) ? MAX_TREADLES : MAX_SHAFTS;
    localparam int unsigned TIE_DEPTH = MAX_TREADLES * MAX_SHAFTS;
    localparam int unsigned TRD_DEPTH = TR_ROWS * MAX_PICKS;
    localparam int unsigned CLR_DEPTH0 = (TIE_DEPTH > TRD_DEPTH) ? TIE_DEPTH : TRD_DEPTH;
    localparam int unsigned CLR_DEPTH = (MAX_WARPS > CLR_DEPTH0) ? MAX_WARPS : CLR_DEPTH0;
    localparam int unsigned THR_AW    = $clog2(MAX_WARPS);
    localparam int unsigned TIE_AW    = $clog2(TIE_DEPTH);
    localparam int unsigned TRD_AW    = $clog2(TRD_DEPTH);
    localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);
    localparam int unsigned KW        = $clog2(MAX_TREADLES);
    localparam int unsigned LW        = $clog2(MAX_TREADLES + 1);

    // Configuration
    logic       r_liftplan;
    logic [8:0] r_warps;
    logic [5:0] r_treadles;
    logic [8:0] r_picks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_liftplan <= 1'b0;
            r_warps    <= RST_WARPS;
            r_treadles <= RST_TREADLES;
            r_picks    <= RST_PICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIFTPLAN: r_liftplan <= i_cfg_wdata[0];
                CFG_WARPS:    r_warps    <= i_cfg_wdata[8:0];
                CFG_TREADLES: r_treadles <= i_cfg_wdata[5:0];
                CFG_PICKS:    r_picks    <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Latched item
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
    end

    // Control counters
    logic [CLR_AW-1:0] r_clr_addr;
    logic [KW-1:0]     r_k;
    logic              r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_k        <= '0;
            r_dv       <= 1'b0;
        end else begin
            r_dv <= i_cmd.scan_rd;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + CLR_AW'(1);
            end
            if (i_cmd.res_clr) begin
                r_k <= '0;
            end else if (i_cmd.scan_rd) begin
                r_k <= r_k + KW'(1);
            end
        end
    end

    // Stores
    logic [5:0] r_thr_mem [MAX_WARPS];
    logic [3:0] r_tie_mem [TIE_DEPTH];
    logic [3:0] r_trd_mem [TRD_DEPTH];
    logic [5:0] r_thr_q;
    logic [3:0] r_tie_q;
    logic [3:0] r_trd_q;

    logic              thr_we,  tie_we,  trd_we;
    logic [THR_AW-1:0] thr_waddr;
    logic [TIE_AW-1:0] tie_waddr, tie_raddr;
    logic [TRD_AW-1:0] trd_waddr, trd_raddr;
    logic [5:0]        thr_wdata;
    logic [3:0]        tie_wdata, trd_wdata;
    logic [5:0]        shaft;

    assign shaft = r_thr_q - 6'd1;

    always_comb begin
        if (i_cmd.clr) begin
            thr_we    = 32'(r_clr_addr) < MAX_WARPS;
            tie_we    = 32'(r_clr_addr) < TIE_DEPTH;
            trd_we    = 32'(r_clr_addr) < TRD_DEPTH;
            thr_waddr = THR_AW'(r_clr_addr);
            tie_waddr = TIE_AW'(r_clr_addr);
            trd_waddr = TRD_AW'(r_clr_addr);
            thr_wdata = '0;
            tie_wdata = '0;
            trd_wdata = '0;
        end else begin
            thr_we = i_cmd.wr && (r_in.op == OP_WR_THREADING)
                     && (32'(r_in.warp_index) < MAX_WARPS);
            tie_we = i_cmd.wr && (r_in.op == OP_WR_TIEUP)
                     && (32'(r_in.treadle_index) < MAX_TREADLES)
                     && (32'(r_in.shaft_index) < MAX_SHAFTS);
            trd_we = i_cmd.wr && (r_in.op == OP_WR_TREADLING)
                     && (32'(r_in.treadle_index) < TR_ROWS)
                     && (32'(r_in.pick_index) < MAX_PICKS);
            thr_waddr = THR_AW'(r_in.warp_index);
            tie_waddr = TIE_AW'(32'(r_in.treadle_index) * MAX_SHAFTS
                                + 32'(r_in.shaft_index));
            trd_waddr = TRD_AW'(32'(r_in.treadle_index) * MAX_PICKS
                                + 32'(r_in.pick_index));
            thr_wdata = r_in.shaft_number;
            tie_wdata = r_in.cell_value;
            trd_wdata = r_in.cell_value;
        end
    end

    assign tie_raddr = TIE_AW'(32'(r_k) * MAX_SHAFTS + 32'(shaft));
    assign trd_raddr = i_cmd.lp_rd ? TRD_AW'(32'(shaft) * MAX_PICKS + 32'(r_in.pick_index))
                                   : TRD_AW'(32'(r_k) * MAX_PICKS + 32'(r_in.pick_index));

    always_ff @(posedge i_clk) begin
        if (thr_we) begin
            r_thr_mem[thr_waddr] <= thr_wdata;
        end
        if (i_cmd.thr_rd) begin
            r_thr_q <= r_thr_mem[THR_AW'(r_in.warp_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tie_we) begin
            r_tie_mem[tie_waddr] <= tie_wdata;
        end
        if (i_cmd.scan_rd) begin
            r_tie_q <= r_tie_mem[tie_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (trd_we) begin
            r_trd_mem[trd_waddr] <= trd_wdata;
        end
        if (i_cmd.scan_rd || i_cmd.lp_rd) begin
            r_trd_q <= r_trd_mem[trd_raddr];
        end
    end

    // Read qualification
    logic [LW-1:0] lim;
    logic          warp_ok, pick_ok, shaft_bad;

    assign lim = (32'(r_treadles) > MAX_TREADLES) ? LW'(MAX_TREADLES) : LW'(r_treadles);
    assign warp_ok = (r_in.warp_index < 8'(r_warps) || r_warps[8])
                     && (32'(r_in.warp_index) < MAX_WARPS);
    assign pick_ok = (r_in.pick_index < 8'(r_picks) || r_picks[8])
                     && (32'(r_in.pick_index) < MAX_PICKS);
    assign shaft_bad = r_liftplan ? (32'(shaft) >= TR_ROWS)
                                  : ((32'(shaft) >= MAX_SHAFTS) || (lim == '0));

    assign o_stat.is_write   = (i_in_data.op != OP_RD_CLOTH);
    assign o_stat.clr_last   = (32'(r_clr_addr) == CLR_DEPTH - 1);
    assign o_stat.early_zero = !warp_ok || !pick_ok || (r_thr_q == 6'd0) || shaft_bad;
    assign o_stat.liftplan   = r_liftplan;
    assign o_stat.k_last     = (32'(r_k) + 32'd1) == 32'(lim);

    // Result: the last qualifying treadle wins
    logic [3:0] r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clr) begin
            r_res <= '0;
        end else if (i_cmd.lp_take) begin
            r_res <= r_trd_q;
        end else if (r_dv && (r_tie_q != 4'd0) && (r_trd_q != 4'd0)) begin
            r_res <= r_tie_q;
        end
    end

    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cloth_value <= r_res;
            r_out.warp_out    <= r_in.warp_index;
            r_out.pick_out    <= r_in.pick_index;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[test/weave_drawdown_test.sv]
`timescale 1ns / 1ps

module weave_drawdown_test;
    import wd_pkg::*;

    localparam int unsigned WARPS_MAX    = 256;
    localparam int unsigned TREADLES_MAX = 32;
    localparam int unsigned PICKS_MAX    = 256;
    localparam int unsigned SHAFTS_MAX   = 32;
    // the treadling store doubles as a lift plan, so it has rows for whichever is larger
    localparam int unsigned ROWS_MAX     = (TREADLES_MAX > SHAFTS_MAX) ? TREADLES_MAX : SHAFTS_MAX;

    localparam int DRAIN_CYCLES = 64;     // longer than the slowest read without a receiver stall
    localparam int LONG_HOLD    = 600;    // receiver hold-off that backs the block up
    localparam int QUIET_LIMIT  = 30000;  // covers the clearing pass over 8192 entries after reset

    typedef enum int {STALL_NONE, STALL_FULL, STALL_HALF, STALL_LIGHT} t_stall_style;

    // Expected cloth cells, built from a private copy of the draft and the registers.
    class drawdown_board;
        logic [5:0] threading_tab [WARPS_MAX];
        logic [3:0] tieup_tab     [TREADLES_MAX * SHAFTS_MAX];
        logic [3:0] treadling_tab [ROWS_MAX * PICKS_MAX];
        logic       liftplan;
        logic [8:0] warps_reg;
        logic [5:0] treadles_reg;
        logic [8:0] picks_reg;
        t_out_item  pending_cells [$];
        int         fail_count;

        function new();
            foreach (threading_tab[i]) threading_tab[i] = '0;
            foreach (tieup_tab[i]) tieup_tab[i] = '0;
            foreach (treadling_tab[i]) treadling_tab[i] = '0;
            liftplan     = 1'b0;
            warps_reg    = RST_WARPS;
            treadles_reg = RST_TREADLES;
            picks_reg    = RST_PICKS;
            fail_count   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LIFTPLAN: liftplan     = data[0];
                CFG_WARPS:    warps_reg    = data;
                CFG_TREADLES: treadles_reg = data[5:0];
                CFG_PICKS:    picks_reg    = data;
                default: ;
            endcase
        endfunction

        function logic [3:0] weave_cell(logic [7:0] warp, logic [7:0] pick);
            int unsigned warp_lim, pick_lim, tread_lim, shaft;
            logic [3:0]  woven;
            warp_lim  = (warps_reg > WARPS_MAX) ? WARPS_MAX : warps_reg;
            pick_lim  = (picks_reg > PICKS_MAX) ? PICKS_MAX : picks_reg;
            tread_lim = (treadles_reg > TREADLES_MAX) ? TREADLES_MAX : treadles_reg;
            woven     = 4'd0;
            if (warp >= warp_lim || pick >= pick_lim || threading_tab[warp] == 6'd0)
                return 4'd0;
            shaft = threading_tab[warp] - 1;
            if (liftplan) begin
                if (shaft >= ROWS_MAX)
                    return 4'd0;
                return treadling_tab[shaft * PICKS_MAX + pick];
            end
            if (shaft >= SHAFTS_MAX)
                return 4'd0;
            // the last pressed treadle with a tie to this shaft wins
            for (int k = 0; k < tread_lim; k++) begin
                if (tieup_tab[k * SHAFTS_MAX + shaft] != 4'd0 &&
                    treadling_tab[k * PICKS_MAX + pick] != 4'd0)
                    woven = tieup_tab[k * SHAFTS_MAX + shaft];
            end
            return woven;
        endfunction

        function void note_item(t_in_item it);
            t_out_item cell_out;
            case (it.op)
                OP_WR_THREADING: threading_tab[it.warp_index] = it.shaft_number;
                OP_WR_TIEUP:
                    tieup_tab[it.treadle_index * SHAFTS_MAX + it.shaft_index] = it.cell_value;
                OP_WR_TREADLING:
                    treadling_tab[it.treadle_index * PICKS_MAX + it.pick_index] = it.cell_value;
                default: begin
                    cell_out.cloth_value = weave_cell(it.warp_index, it.pick_index);
                    cell_out.warp_out    = it.warp_index;
                    cell_out.pick_out    = it.pick_index;
                    pending_cells.push_back(cell_out);
                end
            endcase
        endfunction

        function void check_cell(t_out_item got);
            t_out_item want;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected cloth cell: value %0d warp %0d pick %0d", $time,
                         got.cloth_value, got.warp_out, got.pick_out);
                fail_count++;
                return;
            end
            want = pending_cells.pop_front();
            if (got.cloth_value !== want.cloth_value) begin
                $display("%0t: cloth_value mismatch (warp %0d pick %0d): expected %0d, got %0d",
                         $time, want.warp_out, want.pick_out, want.cloth_value, got.cloth_value);
                fail_count++;
            end
            if (got.warp_out !== want.warp_out) begin
                $display("%0t: warp_out mismatch: expected %0d, got %0d", $time,
                         want.warp_out, got.warp_out);
                fail_count++;
            end
            if (got.pick_out !== want.pick_out) begin
                $display("%0t: pick_out mismatch: expected %0d, got %0d", $time,
                         want.pick_out, got.pick_out);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    drawdown_board board;
    int            burst_left    = 0;
    bit            long_hold_req = 1'b0;
    logic [7:0]    warp_base     = 8'd0;
    logic [7:0]    pick_base     = 8'd0;
    int            quiet_cycles  = 0;

    weave_drawdown #(
        .MAX_WARPS    (WARPS_MAX),
        .MAX_TREADLES (TREADLES_MAX),
        .MAX_PICKS    (PICKS_MAX),
        .MAX_SHAFTS   (SHAFTS_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Note every accepted transaction on both channels from pre-edge values.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            board.note_item(in_data);
        if (rst_n && out_valid && out_ready)
            board.check_cell(out_data);
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("weave_drawdown_test: FAIL");
            $finish;
        end
    end

    // Receiver: stall in segments of random style; once, hold off for a long stretch.
    initial begin : receiver
        int unsigned  seg;
        t_stall_style style;
        out_ready <= 1'b0;
        forever begin
            if (long_hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else begin
                seg   = $urandom_range(1, 40);
                style = t_stall_style'($urandom_range(0, 3));
                repeat (seg) begin
                    case (style)
                        STALL_NONE: out_ready <= 1'b1;
                        STALL_FULL: out_ready <= 1'b0;
                        STALL_HALF: out_ready <= 1'($urandom);
                        default:    out_ready <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic t_in_item mk_item(t_op op, int warp, int pick, int treadle, int shaft,
                                         int number, int value);
        t_in_item it;
        it.op            = op;
        it.warp_index    = 8'(warp);
        it.pick_index    = 8'(pick);
        it.treadle_index = 5'(treadle);
        it.shaft_index   = 5'(shaft);
        it.shaft_number  = 6'(number);
        it.cell_value    = 4'(value);
        return it;
    endfunction

    // Most items land in a small window of warps, picks, treadles and shafts so that
    // reads find threaded warps and tied, pressed treadles; the rest spread everywhere.
    function automatic t_in_item next_item();
        t_in_item    it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            it.op = OP_RD_CLOTH;
        else if (r < 60)
            it.op = OP_WR_THREADING;
        else if (r < 75)
            it.op = OP_WR_TIEUP;
        else
            it.op = OP_WR_TREADLING;
        it.warp_index    = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : warp_base + 8'($urandom_range(0, 7));
        it.pick_index    = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : pick_base + 8'($urandom_range(0, 7));
        it.treadle_index = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
        it.shaft_index   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        if (r == 0)
            it.shaft_number = 6'($urandom);
        else if (r == 1)
            it.shaft_number = 6'd0;
        else
            it.shaft_number = 6'($urandom_range(1, 8));
        it.cell_value = ($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom);
        return it;
    endfunction

    // Offer one transaction and hold it until accepted; gaps fall between bursts.
    task automatic send_item(input t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    // Drop valid, wait for every expected cell, then let any trailing write finish.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_cells.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] mode_w, warps_w, tread_w,
                                 picks_w);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_LIFTPLAN, CFG_WARPS, CFG_TREADLES, CFG_PICKS};
        vals = '{mode_w, warps_w, tread_w, picks_w};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            board.set_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] mode_w, warps_w, tread_w, picks_w,
                             input int n_items, input bit long_hold);
        settle();
        apply_setting(mode_w, warps_w, tread_w, picks_w);
        warp_base = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        pick_base = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        if (long_hold)
            long_hold_req = 1'b1;
        repeat (n_items) send_item(next_item());
    endtask

    initial begin : stimulus
        board = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: store corners, last-treadle priority,
        // shaft numbers beyond the stores and unthreaded warps.
        send_item(mk_item(OP_RD_CLOTH,       0,   0,  0,  0,  0,  0));
        send_item(mk_item(OP_WR_THREADING, 255,   0,  0,  0, 32,  0));
        send_item(mk_item(OP_WR_TIEUP,       0,   0, 31, 31,  0, 15));
        send_item(mk_item(OP_WR_TREADLING,   0, 255, 31,  0,  0, 15));
        send_item(mk_item(OP_RD_CLOTH,     255, 255,  0,  0,  0,  0));
        send_item(mk_item(OP_WR_THREADING,   0,   0,  0,  0,  1,  0));
        send_item(mk_item(OP_WR_TIEUP,       0,   0,  0,  0,  0,  5));
        send_item(mk_item(OP_WR_TIEUP,       0,   0,  3,  0,  0,  9));
        send_item(mk_item(OP_WR_TREADLING,   0,   0,  0,  0,  0,  1));
        send_item(mk_item(OP_RD_CLOTH,       0,   0,  0,  0,  0,  0));
        send_item(mk_item(OP_WR_TREADLING,   0,   0,  3,  0,  0,  2));
        send_item(mk_item(OP_RD_CLOTH,       0,   0,  0,  0,  0,  0));
        send_item(mk_item(OP_WR_TIEUP,       0,   0,  3,  0,  0,  0));
        send_item(mk_item(OP_RD_CLOTH,       0,   0,  0,  0,  0,  0));
        send_item(mk_item(OP_WR_THREADING,   1,   0,  0,  0, 40,  0));
        send_item(mk_item(OP_RD_CLOTH,       1,   0,  0,  0,  0,  0));
        send_item(mk_item(OP_WR_THREADING,   2,   0,  0,  0, 63,  0));
        send_item(mk_item(OP_RD_CLOTH,       2,   0,  0,  0,  0,  0));
        send_item(mk_item(OP_RD_CLOTH,       3,   0,  0,  0,  0,  0));
        repeat (300) send_item(next_item());

        // Smallest draft, lift plan with the long receiver hold-off, oversized sizes,
        // and sizes of zero.
        run_phase(9'd0, 9'd1, 9'd1, 9'd1, 150, 1'b0);
        run_phase(9'd1, 9'd256, 9'd32, 9'd256, 300, 1'b1);
        run_phase(9'd0, 9'd511, 9'd63, 9'd511, 200, 1'b0);
        run_phase(9'd0, 9'd256, 9'd0, 9'd256, 60, 1'b0);
        run_phase(9'h1FF, 9'd0, 9'd32, 9'd300, 60, 1'b0);

        // Random settings; stray upper bits on the narrow registers are dropped.
        repeat (4) begin
            run_phase({8'($urandom), 1'($urandom)}, 9'($urandom_range(1, 256)),
                      {3'($urandom), 6'($urandom_range(1, 32))}, 9'($urandom_range(1, 256)),
                      160, 1'b0);
        end

        settle();
        if (board.fail_count == 0)
            $display("weave_drawdown_test: PASS");
        else
            $display("weave_drawdown_test: FAIL");
        $finish;
    end

endmodule
